>>> rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared widths, constants, codes and the controller state type.
// ----------------------------------------------------------------------------
package blm_pkg;

    localparam int ADC_BITS      = 12;
    localparam int FRAC_BITS     = 8;

    localparam int MV_W          = 13;
    localparam int Q_W           = MV_W + FRAC_BITS;
    localparam int ADC_MAX       = (1 << ADC_BITS) - 1;
    localparam int FULL_SCALE_MV = 7200;

    localparam int ALPHA_W       = 9;
    localparam int ALPHA_ONE     = 256;
    localparam int ALPHA_SHIFT   = 8;

    localparam int PCT_W         = 8;
    localparam int PCT_QB        = 7;
    localparam int PCT_FULL      = 100;
    localparam int LOW_PCT       = 10;
    localparam int CRIT_PCT      = 5;

    // Shared restoring divider: scaling numerator or percent numerator.
    localparam int SCL_W         = ADC_BITS + MV_W;
    localparam int NUM_W         = Q_W + PCT_QB;
    localparam int REM_W         = (SCL_W > NUM_W) ? SCL_W : NUM_W;
    localparam int PROD_W        = Q_W + 1 + ALPHA_W;
    localparam int CNT_W         = 4;

    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        STAT_USB    = 2'd0,
        STAT_CRIT   = 2'd1,
        STAT_LOW    = 2'd2,
        STAT_NORMAL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_USB   = 2'd1,
        REG_EMPTY = 2'd2,
        REG_FULL  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_LOAD,
        ST_EMA,
        ST_APPLY,
        ST_CLASS,
        ST_DIV,
        ST_DONE
    } blm_state_t;

endpackage

>>> rtl/core/blm_if.sv
// ----------------------------------------------------------------------------
// Battery level monitor channels
// Valid/ready channels for converter samples and for monitor results.
// ----------------------------------------------------------------------------
interface blm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [blm_pkg::ADC_BITS-1:0]  adc_code;

    modport source (output valid, output adc_code, input ready);
    modport sink   (input valid, input adc_code, output ready);
endinterface

interface blm_result_if;
    logic                          valid;
    logic                          ready;
    logic [blm_pkg::MV_W-1:0]      smoothed_mv;
    logic                          on_usb;
    logic signed [blm_pkg::PCT_W-1:0] charge_percent;
    logic                          low_flag;
    logic                          critical_flag;
    blm_pkg::status_t              status_code;

    modport source (output valid, output smoothed_mv, output on_usb,
                    output charge_percent, output low_flag,
                    output critical_flag, output status_code, input ready);
    modport sink   (input valid, input smoothed_mv, input on_usb,
                    input charge_percent, input low_flag,
                    input critical_flag, input status_code, output ready);
endinterface

>>> rtl/core/battery_level_monitor.sv
// ----------------------------------------------------------------------------
// Battery level monitor
// Scales converter samples to millivolts, smooths them with an exponential
// moving average and reports USB presence, charge percent and status.
// ----------------------------------------------------------------------------
//
//   channel   direction  beat contents
//   sample    in         adc_code
//   result    out        smoothed_mv, on_usb, charge_percent, low_flag,
//                        critical_flag, status_code
//   apb       in/out     register writes and reads, always ready
//
// After a sample is accepted, the scaling divider runs in SCALE; the first
// sample then loads the average, later ones pass through the EMA multiplier
// and APPLY, and the percent divider runs in DIV only when the percent is
// interpolated; the next sample can be taken in the cycle after the result is loaded.
// A finished result waits in DONE while the sink holds the output register.
// Reset clears the average and the primed state.
//
module battery_level_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blm_pkg::ADDR_W-1:0]   paddr,
    input  logic [blm_pkg::DATA_W-1:0]   pwdata,
    output logic [blm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    blm_sample_if.sink                   sample,
    blm_result_if.source                 result
);

    localparam int MV_W   = blm_pkg::MV_W;
    localparam int Q_W    = blm_pkg::Q_W;
    localparam int REM_W  = blm_pkg::REM_W;
    localparam int PROD_W = blm_pkg::PROD_W;
    localparam int CNT_W  = blm_pkg::CNT_W;
    localparam int AW     = blm_pkg::ALPHA_W;
    localparam int QB     = blm_pkg::PCT_QB;
    localparam int FB     = blm_pkg::FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [AW-1:0]      alpha_reg;
    logic [MV_W-1:0]    usb_thr_reg;
    logic [MV_W-1:0]    empty_reg;
    logic [MV_W-1:0]    full_reg;
    logic               cfg_write;
    blm_pkg::reg_idx_t  cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = blm_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= AW'(26);
            usb_thr_reg <= MV_W'(4500);
            empty_reg   <= MV_W'(3000);
            full_reg    <= MV_W'(4200);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                blm_pkg::REG_ALPHA: alpha_reg   <= pwdata[AW-1:0];
                blm_pkg::REG_USB:   usb_thr_reg <= pwdata[MV_W-1:0];
                blm_pkg::REG_EMPTY: empty_reg   <= pwdata[MV_W-1:0];
                blm_pkg::REG_FULL:  full_reg    <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            blm_pkg::REG_ALPHA: prdata = blm_pkg::DATA_W'(alpha_reg);
            blm_pkg::REG_USB:   prdata = blm_pkg::DATA_W'(usb_thr_reg);
            blm_pkg::REG_EMPTY: prdata = blm_pkg::DATA_W'(empty_reg);
            blm_pkg::REG_FULL:  prdata = blm_pkg::DATA_W'(full_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    blm_pkg::blm_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    div_reg;
    logic [MV_W-1:0]     quo_reg;
    logic [Q_W-1:0]      smooth_reg;
    logic                primed_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mcand_reg;
    logic [AW-1:0]       mplr_reg;
    logic                usb_reg;
    logic [QB-1:0]       pct_reg;
    logic                out_valid_reg;

    // Shared restoring divider step: one quotient bit per cycle.
    logic               step_ge;
    logic [REM_W-1:0]   rem_diff;
    logic [REM_W-1:0]   rem_step;
    logic [MV_W-1:0]    quo_step;

    assign step_ge  = (rem_reg >= div_reg);
    assign rem_diff = step_ge ? (rem_reg - div_reg) : rem_reg;
    assign rem_step = {rem_diff[REM_W-2:0], 1'b0};
    assign quo_step = {quo_reg[MV_W-2:0], step_ge};

    // Average update operands.
    logic [Q_W-1:0]         new_q;
    logic signed [Q_W:0]    delta;
    logic [AW-1:0]          alpha_sat;
    logic signed [PROD_W-1:0] acc_add;
    logic signed [PROD_W-1:0] acc_scaled;

    assign new_q      = {quo_reg, FB'(0)};
    assign delta      = $signed({1'b0, new_q}) - $signed({1'b0, smooth_reg});
    assign alpha_sat  = (alpha_reg > AW'(blm_pkg::ALPHA_ONE)) ?
                        AW'(blm_pkg::ALPHA_ONE) : alpha_reg;
    assign acc_add    = mplr_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign acc_scaled = acc_reg >>> blm_pkg::ALPHA_SHIFT;

    // Classification against the thresholds at full fractional precision.
    logic [Q_W-1:0]     usb_q;
    logic [Q_W-1:0]     empty_q;
    logic [Q_W-1:0]     full_q;
    logic               is_usb;
    logic               at_empty;
    logic               at_full;
    logic [Q_W-1:0]     above_empty;
    logic [MV_W-1:0]    span_mv;

    assign usb_q       = {usb_thr_reg, FB'(0)};
    assign empty_q     = {empty_reg, FB'(0)};
    assign full_q      = {full_reg, FB'(0)};
    assign is_usb      = (smooth_reg > usb_q);
    assign at_empty    = (smooth_reg <= empty_q);
    assign at_full     = (smooth_reg >= full_q);
    assign above_empty = smooth_reg - empty_q;
    assign span_mv     = full_reg - empty_reg;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    logic out_free;
    logic sample_take;
    logic last_step;

    assign out_free    = !out_valid_reg || result.ready;
    assign sample_take = sample.valid && sample.ready;
    assign last_step   = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blm_pkg::ST_IDLE:
                if (sample.valid)
                    state_next = blm_pkg::ST_SCALE;
            blm_pkg::ST_SCALE:
                if (last_step)
                    state_next = blm_pkg::ST_LOAD;
            blm_pkg::ST_LOAD:
                state_next = primed_reg ? blm_pkg::ST_EMA : blm_pkg::ST_CLASS;
            blm_pkg::ST_EMA:
                if (last_step)
                    state_next = blm_pkg::ST_APPLY;
            blm_pkg::ST_APPLY:
                state_next = blm_pkg::ST_CLASS;
            blm_pkg::ST_CLASS:
                if (is_usb || at_empty || at_full)
                    state_next = blm_pkg::ST_DONE;
                else
                    state_next = blm_pkg::ST_DIV;
            blm_pkg::ST_DIV:
                if (last_step)
                    state_next = blm_pkg::ST_DONE;
            blm_pkg::ST_DONE:
                if (out_free)
                    state_next = blm_pkg::ST_IDLE;
            default:
                state_next = blm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample.ready = (state_reg == blm_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= blm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            primed_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                blm_pkg::ST_IDLE:
                    if (sample_take)
                        cnt_reg <= CNT_W'(MV_W);
                blm_pkg::ST_SCALE, blm_pkg::ST_EMA, blm_pkg::ST_DIV:
                    cnt_reg <= cnt_reg - CNT_W'(1);
                blm_pkg::ST_LOAD:
                begin
                    cnt_reg <= CNT_W'(AW);
                    if (!primed_reg)
                    begin
                        smooth_reg <= new_q;
                        primed_reg <= 1'b1;
                    end
                end
                blm_pkg::ST_APPLY:
                    smooth_reg <= smooth_reg + acc_scaled[Q_W-1:0];
                blm_pkg::ST_CLASS:
                    cnt_reg <= CNT_W'(QB);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            blm_pkg::ST_IDLE:
                if (sample_take)
                begin
                    rem_reg <= REM_W'(sample.adc_code) * REM_W'(blm_pkg::FULL_SCALE_MV);
                    div_reg <= REM_W'(blm_pkg::ADC_MAX) << (MV_W - 1);
                    quo_reg <= '0;
                end
            blm_pkg::ST_SCALE, blm_pkg::ST_DIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                if (state_reg == blm_pkg::ST_DIV && last_step)
                    pct_reg <= quo_step[QB-1:0];
            end
            blm_pkg::ST_LOAD:
            begin
                mcand_reg <= PROD_W'(delta);
                mplr_reg  <= alpha_sat;
                acc_reg   <= '0;
            end
            blm_pkg::ST_EMA:
            begin
                acc_reg   <= acc_add;
                mcand_reg <= mcand_reg <<< 1;
                mplr_reg  <= mplr_reg >> 1;
            end
            blm_pkg::ST_CLASS:
            begin
                usb_reg <= is_usb;
                pct_reg <= (!is_usb && !at_empty) ? QB'(blm_pkg::PCT_FULL) : '0;
                rem_reg <= REM_W'(above_empty) * REM_W'(blm_pkg::PCT_FULL);
                div_reg <= REM_W'(span_mv) << (FB + QB - 1);
                quo_reg <= '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (state_reg == blm_pkg::ST_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result.smoothed_mv <= smooth_reg[Q_W-1:FB];
            result.on_usb      <= usb_reg;
            if (usb_reg)
            begin
                result.charge_percent <= -8'sd1;
                result.low_flag       <= 1'b0;
                result.critical_flag  <= 1'b0;
                result.status_code    <= blm_pkg::STAT_USB;
            end
            else
            begin
                result.charge_percent <= $signed({1'b0, pct_reg});
                result.low_flag       <= (pct_reg < QB'(blm_pkg::LOW_PCT));
                result.critical_flag  <= (pct_reg < QB'(blm_pkg::CRIT_PCT));
                if (pct_reg < QB'(blm_pkg::CRIT_PCT))
                    result.status_code <= blm_pkg::STAT_CRIT;
                else if (pct_reg < QB'(blm_pkg::LOW_PCT))
                    result.status_code <= blm_pkg::STAT_LOW;
                else
                    result.status_code <= blm_pkg::STAT_NORMAL;
            end
        end
    end

    assign result.valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam logic [Q_W-1:0] SMOOTH_MAX = {MV_W'(blm_pkg::FULL_SCALE_MV), FB'(0)};

    a_smooth_range: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |-> smooth_reg <= SMOOTH_MAX)
        else $error("smoothed voltage exceeds full scale");

    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("filter lost its primed state");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result.valid && state_reg == blm_pkg::ST_IDLE)
        else $error("finished result not presented");

    a_usb_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.on_usb |->
            result.charge_percent == -8'sd1 &&
            result.status_code == blm_pkg::STAT_USB &&
            !result.low_flag && !result.critical_flag)
        else $error("inconsistent USB result");

endmodule
